// ===== design/cau_pkg.sv =====
package cau_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;

  // root of a 32-bit radicand, two root bits per pipe stage
  localparam int RAD_W                = PROD_W;
  localparam int ROOT_W               = RAD_W / 2;
  localparam int REM_W                = ROOT_W + 2;
  localparam int SQRT_BITS_PER_STAGE  = 2;
  localparam int SQRT_STAGES          = ROOT_W / SQRT_BITS_PER_STAGE;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(32768);
  localparam logic [DATA_W-1:0]       POS_MAX = 16'h7fff;
  localparam logic signed [DATA_W-1:0] UNIT   = 16'sd1;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_RMUL = 3'd2,
    OP_IMUL = 3'd3,
    OP_CMUL = 3'd4,
    OP_MAG  = 3'd5
  } op_t;

  // decoded word: four product lanes, lanes 0/1 sum into re, 2/3 into im
  typedef struct packed {
    logic signed [DATA_W-1:0] x0;
    logic signed [DATA_W-1:0] y0;
    logic signed [DATA_W-1:0] x1;
    logic signed [DATA_W-1:0] y1;
    logic signed [DATA_W-1:0] x2;
    logic signed [DATA_W-1:0] y2;
    logic signed [DATA_W-1:0] x3;
    logic signed [DATA_W-1:0] y3;
    logic [3:0]               neg;
    logic                     shift;
    logic                     mag;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ovf;
  } sat_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_t;

  function automatic sat_t sat16(input logic signed [SUM_W-1:0] v);
    sat_t s;
    if (v > SAT_MAX) begin
      s.val = SAT_MAX[DATA_W-1:0];
      s.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      s.val = SAT_MIN[DATA_W-1:0];
      s.ovf = 1'b1;
    end else begin
      s.val = v[DATA_W-1:0];
      s.ovf = 1'b0;
    end
    return s;
  endfunction

  // one restoring step: brings down the top two radicand bits
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    sqrt_t n;
    cur   = {s.rem, s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      n.rem  = REM_W'(cur - trial);
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = cur[REM_W-1:0];
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic sqrt_t sqrt_stage(input sqrt_t s);
    sqrt_t t;
    t = s;
    for (int i = 0; i < SQRT_BITS_PER_STAGE; i++) begin
      t = sqrt_step(t);
    end
    return t;
  endfunction

endpackage

// ===== design/cau_if.sv =====
interface cau_in_if;
  import cau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               operation;
  logic signed [DATA_W-1:0] a_re;
  logic signed [DATA_W-1:0] a_im;
  logic signed [DATA_W-1:0] b_re;
  logic signed [DATA_W-1:0] b_im;
  logic signed [DATA_W-1:0] scalar;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, scalar, input ready);
  modport sink   (input valid, operation, a_re, a_im, b_re, b_im, scalar, output ready);
  modport mon    (input valid, ready, operation, a_re, a_im, b_re, b_im, scalar);
endinterface

interface cau_out_if;
  import cau_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_re;
  logic signed [DATA_W-1:0] result_im;
  logic                     overflow;

  modport source (output valid, result_re, result_im, overflow, input ready);
  modport sink   (input valid, result_re, result_im, overflow, output ready);
  modport mon    (input valid, ready, result_re, result_im, overflow);
endinterface

// ===== design/complex_arithmetic_unit.sv =====
// Path: a word accepted at the input passes the queue, 2 arithmetic stages, 8 square-root
//   stages and the output register before its result shows valid, for every operation.
// Throughput: one word per cycle while the output is not stalled; the 8-stage root pipe runs at full rate.
// Back pressure on the output stalls the whole back pipe; the 4-deep queue keeps input open.
// Reset (synchronous, active low) clears the valid bits, queue pointers and queue count only.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  // front: handshake and decode of the operation into product lanes
  logic push;
  cmd_t push_cmd;
  logic full;

  // queue to back
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  cau_front u_front (
    .in_ch    (in_ch),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // decouples acceptance from the back pipe's stall
  cau_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (full),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd)
  );

  // back: multiply, sum, root, saturate, output register
  cau_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/cau_front.sv =====
module cau_front
  import cau_pkg::*;
(
  cau_in_if.sink in_ch,
  input  logic   full,
  output logic   push,
  output cmd_t   push_cmd
);

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;

  // route operands onto the product lanes
  always_comb begin
    push_cmd = '0;
    unique case (op_t'(in_ch.operation))
      OP_ADD: begin
        push_cmd.x0 = in_ch.a_re; push_cmd.y0 = UNIT;
        push_cmd.x1 = in_ch.b_re; push_cmd.y1 = UNIT;
        push_cmd.x2 = in_ch.a_im; push_cmd.y2 = UNIT;
        push_cmd.x3 = in_ch.b_im; push_cmd.y3 = UNIT;
      end
      OP_SUB: begin
        push_cmd.x0 = in_ch.a_re; push_cmd.y0 = UNIT;
        push_cmd.x1 = in_ch.b_re; push_cmd.y1 = UNIT;
        push_cmd.x2 = in_ch.a_im; push_cmd.y2 = UNIT;
        push_cmd.x3 = in_ch.b_im; push_cmd.y3 = UNIT;
        push_cmd.neg = 4'b1010;
      end
      OP_RMUL: begin
        push_cmd.x0 = in_ch.a_re; push_cmd.y0 = in_ch.scalar;
        push_cmd.x2 = in_ch.a_im; push_cmd.y2 = in_ch.scalar;
        push_cmd.shift = 1'b1;
      end
      OP_IMUL: begin
        push_cmd.x0 = in_ch.a_im; push_cmd.y0 = in_ch.scalar;
        push_cmd.x2 = in_ch.a_re; push_cmd.y2 = in_ch.scalar;
        push_cmd.neg = 4'b0001;
        push_cmd.shift = 1'b1;
      end
      OP_CMUL: begin
        push_cmd.x0 = in_ch.a_re; push_cmd.y0 = in_ch.b_re;
        push_cmd.x1 = in_ch.a_im; push_cmd.y1 = in_ch.b_im;
        push_cmd.x2 = in_ch.a_re; push_cmd.y2 = in_ch.b_im;
        push_cmd.x3 = in_ch.b_re; push_cmd.y3 = in_ch.a_im;
        push_cmd.neg = 4'b0010;
        push_cmd.shift = 1'b1;
      end
      OP_MAG: begin
        push_cmd.x0 = in_ch.a_re; push_cmd.y0 = in_ch.a_re;
        push_cmd.x1 = in_ch.a_im; push_cmd.y1 = in_ch.a_im;
        push_cmd.mag = 1'b1;
      end
      default: begin
        // undefined codes: all lanes zero, result 0 + 0i
        push_cmd = '0;
      end
    endcase
  end

endmodule

// ===== design/cau_queue.sv =====
module cau_queue
  import cau_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output cmd_t q_cmd
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full    = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/cau_back.sv =====
module cau_back
  import cau_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       pop,
  cau_out_if.source  out_ch
);

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic              ovf;
    logic              mag;
  } carry_t;

  logic en;

  // stage 1: products
  logic                     v1_r;
  logic signed [PROD_W-1:0] m0_r, m1_r, m2_r, m3_r;
  logic [3:0]               neg1_r;
  logic                     shift1_r, mag1_r;

  // stage 2: lane sums
  logic                     v2_r;
  logic signed [SUM_W-1:0]  re_sum_r, im_sum_r;
  logic                     shift2_r, mag2_r;
  logic signed [SUM_W-1:0]  t0, t1, t2, t3;

  // root stages
  logic   qv_r  [SQRT_STAGES];
  sqrt_t  sq_r  [SQRT_STAGES];
  carry_t cy_r  [SQRT_STAGES];
  sqrt_t  sq_init;
  carry_t cy_init;
  logic signed [SUM_W-1:0] re_adj, im_adj;
  sat_t   sat_re, sat_im;

  // output word
  logic              out_valid_r;
  logic [DATA_W-1:0] res_re_r, res_im_r;
  logic              ovf_r;
  carry_t            last;
  logic [ROOT_W-1:0] root_last;

  // whole pipe advances unless the output word is held
  assign en  = !out_valid_r || out_ch.ready;
  assign pop = en && q_valid;

  always_ff @(posedge clk) begin
    if (en) begin
      m0_r     <= q_cmd.x0 * q_cmd.y0;
      m1_r     <= q_cmd.x1 * q_cmd.y1;
      m2_r     <= q_cmd.x2 * q_cmd.y2;
      m3_r     <= q_cmd.x3 * q_cmd.y3;
      neg1_r   <= q_cmd.neg;
      shift1_r <= q_cmd.shift;
      mag1_r   <= q_cmd.mag;
    end
  end

  always_comb begin
    t0 = neg1_r[0] ? -SUM_W'(m0_r) : SUM_W'(m0_r);
    t1 = neg1_r[1] ? -SUM_W'(m1_r) : SUM_W'(m1_r);
    t2 = neg1_r[2] ? -SUM_W'(m2_r) : SUM_W'(m2_r);
    t3 = neg1_r[3] ? -SUM_W'(m3_r) : SUM_W'(m3_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      re_sum_r <= t0 + t1;
      im_sum_r <= t2 + t3;
      shift2_r <= shift1_r;
      mag2_r   <= mag1_r;
    end
  end

  // arithmetic shift is a floor divide by 2^FRAC_BITS
  always_comb begin
    re_adj       = shift2_r ? (re_sum_r >>> FRAC_BITS) : re_sum_r;
    im_adj       = shift2_r ? (im_sum_r >>> FRAC_BITS) : im_sum_r;
    sat_re       = sat16(re_adj);
    sat_im       = sat16(im_adj);
    cy_init.re   = sat_re.val;
    cy_init.im   = sat_im.val;
    cy_init.ovf  = sat_re.ovf || sat_im.ovf;
    cy_init.mag  = mag2_r;
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_init.rad  = re_sum_r[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sqrt_stage(sq_init);
      cy_r[0] <= cy_init;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sq_r[k] <= sqrt_stage(sq_r[k-1]);
        cy_r[k] <= cy_r[k-1];
      end
    end
  end

  assign last      = cy_r[SQRT_STAGES-1];
  assign root_last = sq_r[SQRT_STAGES-1].root;

  always_ff @(posedge clk) begin
    if (en) begin
      if (last.mag) begin
        res_im_r <= '0;
        if (root_last[ROOT_W-1]) begin
          res_re_r <= POS_MAX;
          ovf_r    <= 1'b1;
        end else begin
          res_re_r <= root_last[DATA_W-1:0];
          ovf_r    <= 1'b0;
        end
      end else begin
        res_re_r <= last.re;
        res_im_r <= last.im;
        ovf_r    <= last.ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < SQRT_STAGES; k++) begin
        qv_r[k] <= 1'b0;
      end
    end else if (en) begin
      v1_r    <= q_valid;
      v2_r    <= v1_r;
      qv_r[0] <= v2_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        qv_r[k] <= qv_r[k-1];
      end
      out_valid_r <= qv_r[SQRT_STAGES-1];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.result_re = res_re_r;
  assign out_ch.result_im = res_im_r;
  assign out_ch.overflow  = ovf_r;

endmodule

// ===== design/cau_checker.sv =====
module cau_checker
  import cau_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  cau_in_if.sink    in_ch,
  cau_out_if.source out_ch
);

  // after reset: queue empty, nothing pending at the output
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> (in_ch.ready && !out_ch.valid))
    else $error("state after reset wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      $stable(out_ch.result_re) && $stable(out_ch.result_im) && $stable(out_ch.overflow))
    else $error("output word changed while stalled");

  // overflow only comes with a part pinned at a rail
  a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |->
      (out_ch.result_re == 16'sh7fff) || (out_ch.result_re == -16'sh8000) ||
      (out_ch.result_im == 16'sh7fff) || (out_ch.result_im == -16'sh8000))
    else $error("overflow without saturated part");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
